// ----- rtl/sod_pkg.sv -----
// ----------------------------------------------------------------------------
// Divisor sum package
// Field widths, bounds and elaboration helpers shared by the divisor sum
// block and its checker.
// ----------------------------------------------------------------------------
package sod_pkg;

  localparam int unsigned NUMBER_W = 16;
  localparam int unsigned PRIME_W  = 16;
  localparam int unsigned EXP_W    = 5;
  localparam int unsigned SUM_W    = 19;

  localparam int unsigned NUMBER_MAX = (2 ** NUMBER_W) - 1;
  localparam int unsigned MAX_N_DEF  = 65535;

  // Largest r with r * r <= v, evaluated at elaboration.
  function automatic int unsigned isqrt(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) begin
      r = r + 1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/sum_of_divisors.sv -----
// ----------------------------------------------------------------------------
// Sum of divisors
// Factors each number through a smallest-factor table and emits one beat per
// distinct prime, with the divisor sum on the last beat.
// ----------------------------------------------------------------------------
// Usage: a number beat enters on in_valid_i while in_stall_o is low. The block
// answers with one beat per distinct prime factor, in increasing order, on
// out_valid_o; is_last_o marks the final beat, which also carries the divisor
// sum. Inputs of 0 and 1 give a single beat with prime 0, exponent 0, sum 1.
// A memory holds, for every composite m up to MAX_N, its smallest prime factor
// and the cofactor m / factor; each factor occurrence takes a table read and
// then an update step, and the next number is taken once the last beat is in
// the output register.
// After reset the table is built: every entry is cleared, then the sieve
// writes an entry for each multiple of each candidate factor. in_stall_o stays
// high until the table is complete.
// When out_stall_i is high the output register holds its beat and the
// factoring waits before it would overwrite it.
// ----------------------------------------------------------------------------
module sum_of_divisors #(
  parameter int unsigned MAX_N = sod_pkg::MAX_N_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sod_pkg::NUMBER_W-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sod_pkg::PRIME_W-1:0]  prime_factor_o,
  output logic [sod_pkg::EXP_W-1:0]    exponent_o,
  output logic [sod_pkg::SUM_W-1:0]    divisor_sum_o,
  output logic                         is_last_o
);

  localparam int unsigned TOP_N = (MAX_N < sod_pkg::NUMBER_MAX) ? MAX_N
                                                                  : sod_pkg::NUMBER_MAX;
  localparam int unsigned PMAX  = sod_pkg::isqrt(TOP_N);
  localparam int unsigned PSQ   = PMAX * PMAX;
  localparam int unsigned IW    = $clog2(TOP_N + 1);
  localparam int unsigned FW    = $clog2(PMAX + 1);
  localparam int unsigned EW    = FW + IW;
  localparam int unsigned MW    = sod_pkg::PRIME_W + 1;
  localparam int unsigned SW    = sod_pkg::SUM_W;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_SIEVE  = 6'b000010,
    S_IDLE   = 6'b000100,
    S_LOOKUP = 6'b001000,
    S_STEP   = 6'b010000,
    S_FINAL  = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [IW-1:0]                cnt_q, cnt_d;
  logic [FW-1:0]                p_q, p_d;
  logic [IW-1:0]                k_q, k_d;
  logic [IW-1:0]                m_q, m_d;
  logic [IW-1:0]                n_q, n_d;
  logic [sod_pkg::PRIME_W-1:0]  cur_q, cur_d;
  logic [sod_pkg::EXP_W-1:0]    exp_q, exp_d;
  logic [SW-1:0]                total_q, total_d;
  logic [SW-1:0]                sprev_q, sprev_d;
  logic                         out_valid_q, out_valid_d;
  logic [sod_pkg::PRIME_W-1:0]  out_prime_q, out_prime_d;
  logic [sod_pkg::EXP_W-1:0]    out_exp_q, out_exp_d;
  logic [SW-1:0]                out_sum_q, out_sum_d;
  logic                         out_last_q, out_last_d;

  logic [EW-1:0]                mem [TOP_N+1];
  logic [EW-1:0]                rd_q;
  logic                         mem_we;
  logic [IW-1:0]                mem_wa;
  logic [EW-1:0]                mem_wd;

  logic [FW-1:0]                rd_f;
  logic [IW-1:0]                rd_c;
  logic [IW-1:0]                prime_step;
  logic [IW-1:0]                cof_step;
  logic                         same;
  logic [MW-1:0]                mul_m;
  logic [SW+MW-1:0]             prod;
  logic [SW-1:0]                mac;
  logic                         emit_prev;
  logic                         out_free;
  logic [IW:0]                  m_next;
  logic [FW-1:0]                p_dec;
  logic [2*FW-1:0]              p_dec_sq;
  logic [IW-1:0]                n_in;

  assign rd_f       = rd_q[EW-1:IW];
  assign rd_c       = rd_q[IW-1:0];
  assign prime_step = (rd_f == '0) ? n_q : IW'(rd_f);
  assign cof_step   = (rd_f == '0) ? IW'(1) : rd_c;
  assign same       = (sod_pkg::PRIME_W'(prime_step) == cur_q);
  assign mul_m      = MW'(prime_step);
  assign prod       = total_q * mul_m;
  assign mac        = prod[SW-1:0] + (same ? sprev_q : total_q);
  assign emit_prev  = !same && (cur_q != '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign m_next     = {1'b0, m_q} + (IW + 1)'(p_q);
  assign p_dec      = p_q - FW'(1);
  assign p_dec_sq   = p_dec * p_dec;
  assign n_in       = (number_i > sod_pkg::NUMBER_W'(TOP_N)) ? IW'(TOP_N)
                                                             : IW'(number_i);

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign prime_factor_o = out_prime_q;
  assign exponent_o     = out_exp_q;
  assign divisor_sum_o  = out_sum_q;
  assign is_last_o      = out_last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    k_d         = k_q;
    m_d         = m_q;
    n_d         = n_q;
    cur_d       = cur_q;
    exp_d       = exp_q;
    total_d     = total_q;
    sprev_d     = sprev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_prime_d = out_prime_q;
    out_exp_d   = out_exp_q;
    out_sum_d   = out_sum_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = cnt_q;
    mem_wd      = '0;

    unique case (state_q)
      S_INIT: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + IW'(1);
        p_d    = FW'(PMAX);
        k_d    = IW'(PMAX);
        m_d    = IW'(PSQ);
        if (cnt_q == IW'(TOP_N)) begin
          state_d = (PMAX >= 2) ? S_SIEVE : S_IDLE;
        end
      end
      S_SIEVE: begin
        mem_we = 1'b1;
        mem_wa = m_q;
        mem_wd = {p_q, k_q};
        if (m_next <= (IW + 1)'(TOP_N)) begin
          m_d = m_next[IW-1:0];
          k_d = k_q + IW'(1);
        end else if (p_q == FW'(2)) begin
          state_d = S_IDLE;
        end else begin
          p_d = p_dec;
          k_d = IW'(p_dec);
          m_d = IW'(p_dec_sq);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          n_d     = n_in;
          cur_d   = '0;
          exp_d   = '0;
          total_d = SW'(1);
          sprev_d = SW'(1);
          state_d = (n_in <= IW'(1)) ? S_FINAL : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        if (!emit_prev || out_free) begin
          if (emit_prev) begin
            out_valid_d = 1'b1;
            out_prime_d = cur_q;
            out_exp_d   = exp_q;
            out_sum_d   = '0;
            out_last_d  = 1'b0;
          end
          if (same) begin
            exp_d = exp_q + sod_pkg::EXP_W'(1);
          end else begin
            exp_d   = sod_pkg::EXP_W'(1);
            cur_d   = sod_pkg::PRIME_W'(prime_step);
            sprev_d = total_q;
          end
          total_d = mac;
          n_d     = cof_step;
          state_d = (cof_step == IW'(1)) ? S_FINAL : S_LOOKUP;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prime_d = cur_q;
          out_exp_d   = exp_q;
          out_sum_d   = total_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_q == S_LOOKUP) begin
      rd_q <= mem[n_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    k_q         <= k_d;
    m_q         <= m_d;
    n_q         <= n_d;
    cur_q       <= cur_d;
    exp_q       <= exp_d;
    total_q     <= total_d;
    sprev_q     <= sprev_d;
    out_prime_q <= out_prime_d;
    out_exp_q   <= out_exp_d;
    out_sum_q   <= out_sum_d;
    out_last_q  <= out_last_d;
  end

endmodule

// ----- rtl/sod_checker.sv -----
// ----------------------------------------------------------------------------
// Divisor sum checker
// Port-level assertions for the divisor sum block, bound to its top level.
// ----------------------------------------------------------------------------
module sod_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [sod_pkg::NUMBER_W-1:0] number_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sod_pkg::PRIME_W-1:0]  prime_factor_o,
  input logic [sod_pkg::EXP_W-1:0]    exponent_o,
  input logic [sod_pkg::SUM_W-1:0]    divisor_sum_o,
  input logic                         is_last_o
);

  // A stalled input beat stays on the port unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(number_i))
    else $error("stalled input beat changed");

  // A stalled output beat stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(prime_factor_o) && $stable(exponent_o) &&
      $stable(divisor_sum_o) && $stable(is_last_o))
    else $error("stalled output beat changed");

  // Only one number is factored at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a number is in progress");

  // Beats before the last carry a real prime, a nonzero exponent and no sum.
  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |->
      (divisor_sum_o == '0) && (prime_factor_o >= 2) && (exponent_o != '0))
    else $error("malformed intermediate beat");

  // The last beat always has a nonzero divisor sum.
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> (divisor_sum_o != '0))
    else $error("last beat without a divisor sum");

endmodule

bind sum_of_divisors sod_checker u_sod_checker (.*);

// ----- tb/sum_of_divisors_test.sv -----
// ----------------------------------------------------------------------------
// Sum of divisors testbench
// Sends numbers to the divisor sum block and checks every output beat against
// a local factorization by trial division. It covers directed corner values
// and random numbers: uniform, small, smooth, prime powers, multiples of a
// small prime and values near the top. The sender works in bursts, and the
// receiver stalls in random patterns and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sum_of_divisors_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUILD_LIMIT = 1_500_000;
  localparam int unsigned IDLE_LIMIT  = 5_000;
  localparam int unsigned RANDOM_NUMBERS = 90;
  localparam int unsigned HOLD_AFTER_BEATS = 80;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [sod_pkg::PRIME_W-1:0] prime;
    logic [sod_pkg::EXP_W-1:0]   exponent;
    logic [sod_pkg::SUM_W-1:0]   sum;
    logic                        last;
  } factor_beat_t;

  typedef struct {
    logic [sod_pkg::NUMBER_W-1:0] number;
    bit                           drain_first;
  } number_item_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [sod_pkg::NUMBER_W-1:0] number_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [sod_pkg::PRIME_W-1:0]  prime_factor_o;
  logic [sod_pkg::EXP_W-1:0]    exponent_o;
  logic [sod_pkg::SUM_W-1:0]    divisor_sum_o;
  logic                         is_last_o;

  number_item_t pending_numbers[$];
  factor_beat_t expected_beats[$];
  factor_beat_t beat_due;
  number_item_t next_item;
  int unsigned  mismatches = 0;

  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  int unsigned owed_beats = 0;
  bit          offering;
  logic        flood_inputs = 1'b0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned beats_taken = 0;
  bit          hold_done = 1'b0;
  bit          stall_now;

  int unsigned idle_cycles = 0;
  bit          inputs_started = 1'b0;

  sum_of_divisors dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_i       (number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prime_factor_o (prime_factor_o),
    .exponent_o     (exponent_o),
    .divisor_sum_o  (divisor_sum_o),
    .is_last_o      (is_last_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Factors the number by trial division and queues one beat per distinct
  // prime; the last beat carries the divisor sum.
  function automatic int unsigned predict_divisors(
    input logic [sod_pkg::NUMBER_W-1:0] number
  );
    int unsigned       n;
    int unsigned       p;
    int unsigned       q;
    int unsigned       e;
    int unsigned       cnt;
    longint unsigned   sigma;
    longint unsigned   term;
    longint unsigned   pw;
    factor_beat_t      found[6];
    n = number;
    cnt = 0;
    sigma = 1;
    if (n <= 1) begin
      found[0] = '{prime: '0, exponent: '0, sum: sod_pkg::SUM_W'(1), last: 1'b1};
      expected_beats.insert(expected_beats.size(), found[0]);
      return 1;
    end
    p = 2;
    while (n > 1 && cnt < 6) begin
      if (p * p > n) begin
        q = n;
      end else if (n % p != 0) begin
        q = 0;
      end else begin
        q = p;
      end
      if (q != 0) begin
        e = 0;
        term = 1;
        pw = 1;
        while (n % q == 0) begin
          n = n / q;
          e++;
          pw = pw * q;
          term = term + pw;
        end
        sigma = sigma * term;
        found[cnt] = '{prime: sod_pkg::PRIME_W'(q), exponent: sod_pkg::EXP_W'(e),
                       sum: '0, last: 1'b0};
        cnt++;
      end
      p++;
    end
    found[cnt-1].sum = sod_pkg::SUM_W'(sigma);
    found[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) begin
      expected_beats.insert(expected_beats.size(), found[i]);
    end
    return cnt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      number_i <= '0;
      burst_left = 4;
      gap_left = 0;
      owed_beats = 0;
    end else begin
      offering = in_valid_i;
      if (out_valid_o && !out_stall_i && owed_beats > 0) begin
        owed_beats--;
      end
      if (in_valid_i && !in_stall_o) begin
        owed_beats += predict_divisors(number_i);
        offering = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!offering && pending_numbers.size() > 0) begin
        if (gap_left > 0 && !flood_inputs) begin
          gap_left--;
        end else if (!(pending_numbers[0].drain_first && owed_beats != 0)) begin
          next_item = pending_numbers.pop_front();
          number_i <= next_item.number;
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      flood_inputs <= 1'b0;
    end else begin
      stall_now = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        beats_taken++;
      end
      if (!hold_done && beats_taken >= HOLD_AFTER_BEATS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE: begin
            stall_now = 1'b0;
          end
          STALL_LIGHT: begin
            stall_now = ($urandom_range(0, 3) == 0);
          end
          default: begin
            stall_now = ($urandom_range(0, 3) != 0);
          end
        endcase
      end
      out_stall_i <= stall_now;
      flood_inputs <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected beat: prime %0d exponent %0d sum %0d last %0b",
                   prime_factor_o, exponent_o, divisor_sum_o, is_last_o);
        end
      end else begin
        beat_due = expected_beats.pop_front();
        if (prime_factor_o !== beat_due.prime || exponent_o !== beat_due.exponent ||
            divisor_sum_o !== beat_due.sum || is_last_o !== beat_due.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     beat_due.prime, beat_due.exponent, beat_due.sum, beat_due.last,
                     prime_factor_o, exponent_o, divisor_sum_o, is_last_o);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < (inputs_started ? IDLE_LIMIT : BUILD_LIMIT)) begin
      @(posedge clk_i);
      if (rst_ni && in_valid_i && !in_stall_o) begin
        inputs_started = 1'b1;
        idle_cycles = 0;
      end else if (rst_ni && out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned directed[] = '{0, 1, 2, 3, 4, 6, 49, 961, 57121, 32768, 59049, 65025,
                                30030, 2310, 55440, 65535, 65534, 65521, 65498, 45045,
                                27720};
    int unsigned small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                    47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103,
                                    107, 109, 113, 127, 131, 137, 139, 149, 151, 157, 163,
                                    167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227,
                                    229, 233, 239, 241, 251};
    int unsigned value;
    int unsigned p;
    int unsigned kind;
    number_item_t item;
    foreach (directed[i]) begin
      item.number = sod_pkg::NUMBER_W'(directed[i]);
      item.drain_first = 1'b0;
      pending_numbers.insert(pending_numbers.size(), item);
    end
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        value = $urandom_range(0, sod_pkg::NUMBER_MAX);
      end else if (kind == 3) begin
        value = $urandom_range(0, 64);
      end else if (kind <= 6) begin
        value = 1;
        for (int t = 0; t < 12; t++) begin
          p = small_primes[$urandom_range(0, $urandom_range(0, small_primes.size() - 1))];
          if (value * p <= sod_pkg::NUMBER_MAX) begin
            value = value * p;
          end
        end
      end else if (kind == 7) begin
        p = small_primes[$urandom_range(0, small_primes.size() - 1)];
        value = p;
        while (value * p <= sod_pkg::NUMBER_MAX && $urandom_range(0, 4) != 0) begin
          value = value * p;
        end
      end else if (kind == 8) begin
        p = small_primes[$urandom_range(0, small_primes.size() - 1)];
        value = p * $urandom_range(1, sod_pkg::NUMBER_MAX / p);
      end else begin
        value = $urandom_range(65000, sod_pkg::NUMBER_MAX);
      end
      item.number = sod_pkg::NUMBER_W'(value);
      item.drain_first = (i == 0 || i == 60);
      pending_numbers.insert(pending_numbers.size(), item);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_numbers.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
